// ----- rtl/core/gns_pkg.sv -----
`default_nettype none

package gns_pkg;

  localparam int SPEED_W   = 16;
  localparam int STEP_W    = 16;
  localparam int FRAC_BITS = 2;
  localparam int ALPHA_SH  = 2;
  localparam int RATE_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 16;

  // speed in fixed point, step span and its magnitude
  localparam int V_W   = SPEED_W + FRAC_BITS;
  localparam int R_W   = STEP_W + 1;
  localparam int MAG_W = STEP_W;
  localparam int Q_W   = STEP_W;
  localparam int PROD_W = V_W + MAG_W;
  localparam int P_W    = PROD_W + 1;
  localparam int N_W    = PROD_W + 1;
  localparam int D_W    = V_W + 1;
  localparam int ITER_N = (V_W > Q_W) ? V_W : Q_W;
  localparam int CNT_W  = $clog2(ITER_N + 1);

  localparam logic signed [R_W-1:0] JUMP_LIMIT = R_W'(20);

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_RATE = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_FAST_RATE   = CFG_IDX_W'(4);

  localparam logic [SPEED_W-1:0] RST_MAX_SPEED   = SPEED_W'(16000);
  localparam logic [STEP_W-1:0]  RST_MIN_STEP    = STEP_W'(0);
  localparam logic [STEP_W-1:0]  RST_MAX_STEP    = STEP_W'(3780);
  localparam logic [RATE_W-1:0]  RST_NORMAL_RATE = RATE_W'(800);
  localparam logic [RATE_W-1:0]  RST_FAST_RATE   = RATE_W'(3000);

  typedef struct packed {
    logic [SPEED_W-1:0] max_speed;
    logic [STEP_W-1:0]  min_step;
    logic [STEP_W-1:0]  max_step;
  } scale_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } scale_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/gauge_needle_target_smoother_core.sv -----
// Needle target smoother: each input beat carries a speed reading and the motor's present
// step position; one output beat returns the step target of the smoothed speed with the
// chosen step rate. One item is in flight at a time; the block takes no new input beat
// until the last item has been loaded into the output register. The speed to step mapping
// runs twice per item on a single bit-serial unit, and each run goes through a start
// step, the multiply steps, a bias step, the divide steps, a finishing step and a done
// flag. Between the two runs the smoothing update takes place in T_SMOOTH. After the
// second run T_OUT loads the output register and the block returns to idle to take the
// next beat; a full output register that waits on out_ready holds the item in T_OUT. A
// finished result waits in the output register while the next beat is taken. The user
// must write configuration through cfg_we / cfg_index / cfg_data only while the block is
// idle; the block does not enforce this. Unknown indexes are ignored.
`default_nettype none

module gauge_needle_target_smoother_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [gns_pkg::SPEED_W:0]       in_speed_reading,
  input  logic                            in_reading_invalid,
  input  logic [gns_pkg::STEP_W-1:0]      in_needle_position,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gns_pkg::STEP_W-1:0]      out_target_step,
  output logic [gns_pkg::RATE_W-1:0]      out_step_rate,
  output logic                            out_fast_move,
  input  logic                            cfg_we,
  input  logic [gns_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gns_pkg::CFG_DW-1:0]      cfg_data
);

  localparam int SPEED_W = gns_pkg::SPEED_W;
  localparam int STEP_W  = gns_pkg::STEP_W;
  localparam int RATE_W  = gns_pkg::RATE_W;
  localparam int V_W     = gns_pkg::V_W;
  localparam int R_W     = gns_pkg::R_W;
  localparam int FRAC    = gns_pkg::FRAC_BITS;
  localparam int ASH     = gns_pkg::ALPHA_SH;

  localparam logic [2:0] T_IDLE   = 3'd0;
  localparam logic [2:0] T_RAW    = 3'd1;
  localparam logic [2:0] T_SMOOTH = 3'd2;
  localparam logic [2:0] T_TGT    = 3'd3;
  localparam logic [2:0] T_OUT    = 3'd4;

  logic [SPEED_W-1:0] max_speed_r;
  logic [STEP_W-1:0]  min_step_r;
  logic [STEP_W-1:0]  max_step_r;
  logic [RATE_W-1:0]  normal_rate_r;
  logic [RATE_W-1:0]  fast_rate_r;

  logic [2:0]         state_r, state_nxt;
  logic [SPEED_W-1:0] c_r, c_nxt;
  logic [STEP_W-1:0]  pos_r, pos_nxt;
  logic [V_W-1:0]     s_r, s_nxt;
  logic               fast_r, fast_nxt;
  logic               jump_r, jump_nxt;
  logic               start_r, start_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [STEP_W-1:0]  otgt_r, otgt_nxt;
  logic [RATE_W-1:0]  orate_r, orate_nxt;
  logic               ofast_r, ofast_nxt;

  logic               in_acc;
  logic [SPEED_W-1:0] c_in;
  logic [V_W-1:0]     c_fix;
  logic [R_W-1:0]     gap;
  logic [V_W:0]       dlt;
  logic [V_W:0]       dmag;
  logic [V_W:0]       inc;
  logic [V_W-1:0]     s_sm;
  logic               out_free;

  gns_pkg::scale_cfg_t  sc_cfg;
  gns_pkg::scale_stat_t sc_stat;
  logic [V_W-1:0]       sc_v;
  logic [STEP_W-1:0]    sc_step;

  assign sc_cfg.max_speed = max_speed_r;
  assign sc_cfg.min_step  = min_step_r;
  assign sc_cfg.max_step  = max_step_r;
  assign sc_v = (state_r == T_RAW) ? c_fix : s_r;

  gns_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .v     (sc_v),
    .cfg   (sc_cfg),
    .stat  (sc_stat),
    .step  (sc_step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r   <= gns_pkg::RST_MAX_SPEED;
      min_step_r    <= gns_pkg::RST_MIN_STEP;
      max_step_r    <= gns_pkg::RST_MAX_STEP;
      normal_rate_r <= gns_pkg::RST_NORMAL_RATE;
      fast_rate_r   <= gns_pkg::RST_FAST_RATE;
    end else if (cfg_we) begin
      case (cfg_index)
        gns_pkg::REG_MAX_SPEED:   max_speed_r   <= cfg_data[SPEED_W-1:0];
        gns_pkg::REG_MIN_STEP:    min_step_r    <= cfg_data[STEP_W-1:0];
        gns_pkg::REG_MAX_STEP:    max_step_r    <= cfg_data[STEP_W-1:0];
        gns_pkg::REG_NORMAL_RATE: normal_rate_r <= cfg_data[RATE_W-1:0];
        gns_pkg::REG_FAST_RATE:   fast_rate_r   <= cfg_data[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_ready = (state_r == T_IDLE);
    in_acc   = in_valid && in_ready;
    // invalid or negative reads as zero, clamp at full scale
    if (in_reading_invalid || in_speed_reading[SPEED_W]) begin
      c_in = '0;
    end else if (in_speed_reading[SPEED_W-1:0] > max_speed_r) begin
      c_in = max_speed_r;
    end else begin
      c_in = in_speed_reading[SPEED_W-1:0];
    end
    c_fix = {c_r, {FRAC{1'b0}}};
    gap   = {sc_step[STEP_W-1], sc_step} - {pos_r[STEP_W-1], pos_r};
    // quarter step toward the reading, rounded half away from zero
    dlt   = {1'b0, c_fix} - {1'b0, s_r};
    dmag  = dlt[V_W] ? (~dlt + (V_W+1)'(1)) : dlt;
    inc   = (dmag + (V_W+1)'(1 << (ASH - 1))) >> ASH;
    s_sm  = dlt[V_W] ? (s_r - inc[V_W-1:0]) : (s_r + inc[V_W-1:0]);
    out_free = !ovalid_r || out_ready;
  end

  always_comb begin
    state_nxt  = state_r;
    c_nxt      = c_r;
    pos_nxt    = pos_r;
    s_nxt      = s_r;
    fast_nxt   = fast_r;
    jump_nxt   = jump_r;
    start_nxt  = 1'b0;
    ovalid_nxt = ovalid_r && !out_ready;
    otgt_nxt   = otgt_r;
    orate_nxt  = orate_r;
    ofast_nxt  = ofast_r;
    case (state_r)
      T_IDLE: begin
        if (in_acc) begin
          c_nxt     = c_in;
          pos_nxt   = in_needle_position;
          start_nxt = 1'b1;
          state_nxt = T_RAW;
        end
      end
      T_RAW: begin
        if (sc_stat.done) begin
          fast_nxt  = ($signed(gap) > $signed(gns_pkg::JUMP_LIMIT)) ||
                      ($signed(gap) < -$signed(gns_pkg::JUMP_LIMIT));
          jump_nxt  = ($signed(gap) < -$signed(gns_pkg::JUMP_LIMIT));
          state_nxt = T_SMOOTH;
        end
      end
      T_SMOOTH: begin
        s_nxt     = jump_r ? c_fix : s_sm;
        start_nxt = 1'b1;
        state_nxt = T_TGT;
      end
      T_TGT: begin
        if (sc_stat.done) begin
          state_nxt = T_OUT;
        end
      end
      T_OUT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          otgt_nxt   = sc_step;
          orate_nxt  = fast_r ? fast_rate_r : normal_rate_r;
          ofast_nxt  = fast_r;
          state_nxt  = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= T_IDLE;
      s_r      <= '0;
      start_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      s_r      <= s_nxt;
      start_r  <= start_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r     <= c_nxt;
    pos_r   <= pos_nxt;
    fast_r  <= fast_nxt;
    jump_r  <= jump_nxt;
    otgt_r  <= otgt_nxt;
    orate_r <= orate_nxt;
    ofast_r <= ofast_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_target_step = otgt_r;
  assign out_step_rate   = orate_r;
  assign out_fast_move   = ofast_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sc_stat.done |-> (state_r == T_RAW || state_r == T_TGT))
    else $error("mapping unit finished outside a wait state");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> !sc_stat.busy)
    else $error("mapping unit started while busy");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("second beat taken while an item is in flight");

  a_rate_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_OUT && out_free) |=> (out_fast_move == $past(fast_r)))
    else $error("fast move flag lost on output load");

endmodule

`default_nettype wire

// ----- rtl/core/gns_scale.sv -----
`default_nettype none

module gns_scale (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gns_pkg::V_W-1:0]    v,
  input  gns_pkg::scale_cfg_t        cfg,
  output gns_pkg::scale_stat_t       stat,
  output logic [gns_pkg::STEP_W-1:0] step
);

  localparam int V_W    = gns_pkg::V_W;
  localparam int R_W    = gns_pkg::R_W;
  localparam int MAG_W  = gns_pkg::MAG_W;
  localparam int Q_W    = gns_pkg::Q_W;
  localparam int PROD_W = gns_pkg::PROD_W;
  localparam int P_W    = gns_pkg::P_W;
  localparam int N_W    = gns_pkg::N_W;
  localparam int D_W    = gns_pkg::D_W;
  localparam int CNT_W  = gns_pkg::CNT_W;
  localparam int STEP_W = gns_pkg::STEP_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [P_W-1:0]    p_r, p_nxt;
  logic [MAG_W-1:0]  mr_r, mr_nxt;
  logic              neg_r, neg_nxt;
  logic              zero_r, zero_nxt;
  logic [D_W-1:0]    rem_r, rem_nxt;
  logic [Q_W-1:0]    quo_r, quo_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              done_r, done_nxt;

  logic [V_W-1:0]    full;
  logic [V_W-1:0]    vc;
  logic [R_W-1:0]    rng;
  logic [R_W-1:0]    rabs;
  logic [MAG_W:0]    acc;
  logic [N_W-1:0]    num;
  logic [D_W-1:0]    den;
  logic [D_W:0]      trial;
  logic [D_W:0]      diff;
  logic              ge;
  logic [STEP_W:0]   sq;
  logic [STEP_W:0]   sum;

  always_comb begin
    full  = {cfg.max_speed, {gns_pkg::FRAC_BITS{1'b0}}};
    vc    = (v > full) ? full : v;
    rng   = {cfg.max_step[STEP_W-1], cfg.max_step} - {cfg.min_step[STEP_W-1], cfg.min_step};
    rabs  = rng[R_W-1] ? (~rng + R_W'(1)) : rng;
    acc   = p_r[P_W-1:V_W] + (p_r[0] ? {1'b0, mr_r} : {(MAG_W+1){1'b0}});
    num   = {p_r[PROD_W-1:0], 1'b0} + N_W'(full);
    den   = {full, 1'b0};
    trial = {rem_r, quo_r[Q_W-1]};
    diff  = trial - {1'b0, den};
    ge    = (trial >= {1'b0, den});
    sq    = neg_r ? (~{1'b0, quo_r} + (STEP_W+1)'(1)) : {1'b0, quo_r};
    sum   = {cfg.min_step[STEP_W-1], cfg.min_step} + sq;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    p_nxt     = p_r;
    mr_nxt    = mr_r;
    neg_nxt   = neg_r;
    zero_nxt  = zero_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    step_nxt  = step_r;
    done_nxt  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          p_nxt     = {{(MAG_W+1){1'b0}}, vc};
          mr_nxt    = rabs[MAG_W-1:0];
          neg_nxt   = rng[R_W-1];
          zero_nxt  = (cfg.max_speed == '0);
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // shift-add, one multiplier bit a cycle
        p_nxt   = {1'b0, acc, p_r[V_W-1:1]};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(V_W - 1)) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        // rounding bias, then top slice of the dividend seeds the remainder
        rem_nxt   = num[N_W-1:Q_W];
        quo_nxt   = num[Q_W-1:0];
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // restoring division, one quotient bit a cycle
        rem_nxt = ge ? diff[D_W-1:0] : trial[D_W-1:0];
        quo_nxt = {quo_r[Q_W-2:0], ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        step_nxt  = zero_r ? cfg.min_step : sum[STEP_W-1:0];
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    mr_r   <= mr_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = done_r;
  assign step      = step_r;

endmodule

`default_nettype wire

// ----- test/tb_gauge_needle_target_smoother_core.sv -----
`default_nettype none

module tb_gauge_needle_target_smoother_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SPEED_W   = gns_pkg::SPEED_W;
  localparam int STEP_W    = gns_pkg::STEP_W;
  localparam int RATE_W    = gns_pkg::RATE_W;
  localparam int V_W       = gns_pkg::V_W;
  localparam int FRAC_BITS = gns_pkg::FRAC_BITS;
  localparam int ALPHA_SH  = gns_pkg::ALPHA_SH;
  localparam int CFG_IDX_W = gns_pkg::CFG_IDX_W;
  localparam int CFG_DW    = gns_pkg::CFG_DW;

  localparam int RD_W        = SPEED_W + 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 160;

  typedef struct packed {
    logic signed [RD_W-1:0]   reading;
    logic                     invalid;
    logic signed [STEP_W-1:0] position;
  } speed_beat_t;

  typedef struct packed {
    logic signed [STEP_W-1:0] target;
    logic [RATE_W-1:0]        rate;
    logic                     fast;
  } needle_cmd_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [SPEED_W:0]       in_speed_reading = '0;
  logic                   in_reading_invalid = 1'b0;
  logic [STEP_W-1:0]      in_needle_position = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STEP_W-1:0]      out_target_step;
  logic [RATE_W-1:0]      out_step_rate;
  logic                   out_fast_move;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]      cfg_data = '0;

  gauge_needle_target_smoother_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_speed_reading   (in_speed_reading),
    .in_reading_invalid (in_reading_invalid),
    .in_needle_position (in_needle_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_target_step    (out_target_step),
    .out_step_rate      (out_step_rate),
    .out_fast_move      (out_fast_move),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // scale settings and smoothing state as the block should hold them
  logic [SPEED_W-1:0]       full_scale;
  logic signed [STEP_W-1:0] zero_step;
  logic signed [STEP_W-1:0] top_step;
  logic [RATE_W-1:0]        slow_rate;
  logic [RATE_W-1:0]        quick_rate;
  logic [V_W-1:0]           smoothed;

  speed_beat_t   beat_q[$];
  needle_cmd_t   cmd_q[$];
  speed_beat_t   cur_beat;
  longint        last_reading = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            mismatches = 0;
  int            cycles = 0;
  logic          hold_arm = 1'b0;
  logic          hold_done = 1'b0;
  int            hold_left = 0;
  logic          hold_off;

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint speed_to_step(longint v);
    longint full;
    longint span;
    full = longint'(full_scale) << FRAC_BITS;
    span = longint'(top_step) - longint'(zero_step);
    if (full_scale == '0) return longint'(zero_step);
    if (v > full) v = full;
    return longint'(zero_step) + round_div(v * span, full);
  endfunction

  function automatic longint clamp_reading(speed_beat_t b);
    longint rd;
    rd = longint'($signed(b.reading));
    if (b.invalid || rd < 0) return 0;
    if (rd > longint'(full_scale)) return longint'(full_scale);
    return rd;
  endfunction

  function automatic needle_cmd_t predict_needle(speed_beat_t b);
    longint c;
    longint raw;
    longint gap;
    longint lim;
    needle_cmd_t r;
    c = clamp_reading(b) << FRAC_BITS;
    raw = speed_to_step(c);
    gap = raw - longint'($signed(b.position));
    lim = longint'(gns_pkg::JUMP_LIMIT);
    if (gap < -lim) begin
      smoothed = V_W'(c);
    end else begin
      smoothed = V_W'(longint'(smoothed) +
                      round_div(c - longint'(smoothed), longint'(1) << ALPHA_SH));
    end
    r.fast = (gap > lim) || (gap < -lim);
    r.rate = r.fast ? quick_rate : slow_rate;
    r.target = STEP_W'(speed_to_step(longint'(smoothed)));
    return r;
  endfunction

  function automatic speed_beat_t random_beat();
    speed_beat_t b;
    int pick;
    longint raw;
    pick = $urandom_range(99);
    b.invalid = ($urandom_range(9) == 0);
    if (pick < 25) begin
      b.reading = RD_W'(last_reading);
    end else if (pick < 65) begin
      b.reading = RD_W'(longint'($urandom_range(full_scale)));
    end else if (pick < 75) begin
      b.reading = RD_W'(longint'(full_scale) + longint'($urandom_range(64)));
    end else if (pick < 85) begin
      b.reading = RD_W'(-longint'($urandom_range(65536)));
    end else begin
      b.reading = RD_W'($urandom);
    end
    last_reading = longint'($signed(b.reading));
    raw = speed_to_step(clamp_reading(b) << FRAC_BITS);
    if ($urandom_range(99) < 70) begin
      b.position = STEP_W'(raw + longint'($urandom_range(60)) - 30);
    end else begin
      b.position = STEP_W'($urandom);
    end
    return b;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  task automatic offer(longint rd, logic inv, longint pos);
    speed_beat_t b;
    b.reading = RD_W'(rd);
    b.invalid = inv;
    b.position = STEP_W'(pos);
    beat_q.push_back(b);
  endtask

  task automatic drain();
    while (beat_q.size() != 0 || in_valid || cmd_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DW'(val);
    case (idx)
      gns_pkg::REG_MAX_SPEED:   full_scale = SPEED_W'(val);
      gns_pkg::REG_MIN_STEP:    zero_step = STEP_W'(val);
      gns_pkg::REG_MAX_STEP:    top_step = STEP_W'(val);
      gns_pkg::REG_NORMAL_RATE: slow_rate = RATE_W'(val);
      gns_pkg::REG_FAST_RATE:   quick_rate = RATE_W'(val);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_scale(longint ms, longint mn, longint mx, longint nr, longint fr);
    write_reg(gns_pkg::REG_MAX_SPEED, ms);
    write_reg(gns_pkg::REG_MIN_STEP, mn);
    write_reg(gns_pkg::REG_MAX_STEP, mx);
    write_reg(gns_pkg::REG_NORMAL_RATE, nr);
    write_reg(gns_pkg::REG_FAST_RATE, fr);
  endtask

  task automatic run_phase(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (PHASE_ITEMS) beat_q.push_back(random_beat());
    drain();
  endtask

  always @(posedge clk) begin : drive
    speed_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      smoothed = '0;
    end else begin
      if (in_valid && in_ready) cmd_q.push_back(predict_needle(cur_beat));
      if (!in_valid || in_ready) begin
        if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = beat_q.pop_front();
          cur_beat <= nxt;
          in_speed_reading <= nxt.reading;
          in_reading_invalid <= nxt.invalid;
          in_needle_position <= nxt.position;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    needle_cmd_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (cmd_q.size() == 0) begin
          report_mismatch("unexpected beat, target_step", $signed(out_target_step), 0);
        end else begin
          want = cmd_q.pop_front();
          if (out_target_step !== want.target)
            report_mismatch("target_step", $signed(out_target_step), want.target);
          if (out_step_rate !== want.rate)
            report_mismatch("step_rate", out_step_rate, want.rate);
          if (out_fast_move !== want.fast)
            report_mismatch("fast_move", out_fast_move, want.fast);
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off so the block backs up onto its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_arm && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  assign hold_off = (hold_left != 0);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_gauge_needle_target_smoother_core NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    longint mid;
    full_scale = gns_pkg::RST_MAX_SPEED;
    zero_step = gns_pkg::RST_MIN_STEP;
    top_step = gns_pkg::RST_MAX_STEP;
    slow_rate = gns_pkg::RST_NORMAL_RATE;
    quick_rate = gns_pkg::RST_FAST_RATE;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: field extremes, negative and invalid readings
    offer(0, 1'b0, 0);
    offer(16000, 1'b0, 0);
    offer(65535, 1'b0, 3780);
    offer(-1, 1'b0, 0);
    offer(-65536, 1'b0, 32767);
    offer(8000, 1'b1, 0);
    offer(8000, 1'b0, -32768);
    offer(8000, 1'b0, 32767);
    // either side of the jump distance
    mid = speed_to_step(longint'(8000) << FRAC_BITS);
    offer(8000, 1'b0, mid + 20);
    offer(8000, 1'b0, mid + 21);
    offer(8000, 1'b0, mid - 20);
    offer(8000, 1'b0, mid - 21);
    drain();

    // zero full scale
    write_reg(gns_pkg::REG_MAX_SPEED, 0);
    offer(100, 1'b0, 0);
    offer(-5, 1'b0, 50);
    offer(65535, 1'b0, -50);
    drain();

    // full scale lowered below the held smoothed speed
    write_reg(gns_pkg::REG_MAX_SPEED, 16000);
    repeat (4) offer(16000, 1'b0, 3780);
    drain();
    write_reg(gns_pkg::REG_MAX_SPEED, 4000);
    offer(4000, 1'b0, 3780);
    offer(2000, 1'b0, 3780);
    drain();

    // unused register indexes change nothing
    for (int i = gns_pkg::REG_FAST_RATE + 1; i < 2 ** CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), 16'hFFFF);
    offer(16000, 1'b0, 0);
    drain();

    set_scale(16000, 0, 3780, 800, 3000);
    run_phase(0, 0);
    set_scale(65535, -32768, 32767, 0, 65535);
    run_phase(57, 0);
    set_scale(0, -100, 100, 65535, 0);
    run_phase(0, 57);
    set_scale(1, 32767, -32768, 1, 2);
    run_phase(16, 16);
    set_scale(300, -50, 50, 123, 4567);
    hold_arm = 1'b1;
    run_phase(0, 0);
    set_scale(65535, 32767, -32768, 65535, 65535);
    run_phase(57, 0);
    set_scale($urandom_range(65535), $urandom, $urandom, $urandom, $urandom);
    run_phase(0, 57);
    set_scale($urandom_range(2000), $urandom, $urandom, $urandom, $urandom);
    run_phase(16, 16);

    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_gauge_needle_target_smoother_core OK");
    end else begin
      $display("tb_gauge_needle_target_smoother_core NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
